// File: rtl/sha_md_pkg.sv
// Shared types and constants for the SHA-256 message digest core.
// No dependencies; compiled first.
package sha_md_pkg;

  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 32;
  localparam int IDX_W    = 3;
  localparam int RND_W    = 6;
  localparam int COUNT_W  = 61;
  localparam int DIG_WORDS = 8;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIG_WORDS - 1);
  localparam logic [RND_W-1:0] LAST_RND = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             absorb;    // write the incoming byte and count it
    logic             pad;       // 0x80, zero fill and length (when it fits)
    logic             len_blk;   // all-zero block with the length at its end
    logic             load;      // copy the chaining words into a..h
    logic             round;     // one compression round
    logic             add;       // fold a..h back into the chaining words
    logic             restart;   // initial hash values, zero length
    logic [RND_W-1:0] rnd_idx;   // round number for the constant table
  } sha_md_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pos_last;   // next byte lands in the last slot of the block
    logic pos_hi;     // at most eight free bytes: length needs a new block
  } sha_md_sts_t;

endpackage

// File: rtl/sha_md_in_if.sv
// Input channel of the SHA-256 core: at most one message byte per word.
// Depends on sha_md_pkg.
interface sha_md_in_if import sha_md_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              has_byte;
  logic              end_of_message;

  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

// File: rtl/sha_md_out_if.sv
// Result channel of the SHA-256 core: one digest word per handshake.
// Depends on sha_md_pkg.
interface sha_md_out_if import sha_md_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] digest_word;
  logic [IDX_W-1:0]  word_index;
  logic              last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: rtl/sha_md_ctrl.sv
// Sequencer of the SHA-256 core: byte intake, padding, rounds and digest readout.
// Depends on sha_md_pkg.
module sha_md_ctrl import sha_md_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_has_byte,
  input  logic             in_eom,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [IDX_W-1:0] word_idx,
  input  sha_md_sts_t      sts,
  output sha_md_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LEN, S_LOAD, S_ROUND, S_ADD, S_EMIT
  } state_t;

  // What follows once the current compression is folded in.
  typedef enum logic [1:0] {
    A_IDLE, A_PAD, A_LEN, A_EMIT
  } after_t;

  state_t           state_r;
  after_t           aft_r;
  logic [RND_W-1:0] rnd_r;
  logic [IDX_W-1:0] idx_r;
  logic             out_valid_r;
  logic             take;

  assign in_ready  = (state_r == S_IDLE);
  assign take      = in_ready && in_valid;
  assign out_valid = out_valid_r;
  assign word_idx  = idx_r;

  always_comb begin
    cmd         = '0;
    cmd.absorb  = take && in_has_byte;
    cmd.pad     = (state_r == S_PAD);
    cmd.len_blk = (state_r == S_LEN);
    cmd.load    = (state_r == S_LOAD);
    cmd.round   = (state_r == S_ROUND);
    cmd.add     = (state_r == S_ADD);
    cmd.restart = out_valid_r && out_ready && (idx_r == LAST_IDX);
    cmd.rnd_idx = rnd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      aft_r       <= A_IDLE;
      rnd_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (take) begin
            if (in_has_byte && sts.pos_last) begin
              // The byte completes a block; pad afterwards if it was the last.
              state_r <= S_LOAD;
              aft_r   <= in_eom ? A_PAD : A_IDLE;
            end else if (in_eom) begin
              state_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          state_r <= S_LOAD;
          aft_r   <= sts.pos_hi ? A_LEN : A_EMIT;
        end
        S_LEN: begin
          state_r <= S_LOAD;
          aft_r   <= A_EMIT;
        end
        S_LOAD: begin
          state_r <= S_ROUND;
          rnd_r   <= '0;
        end
        S_ROUND: begin
          rnd_r <= rnd_r + 1'b1;
          if (rnd_r == LAST_RND) begin
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          case (aft_r)
            A_IDLE: state_r <= S_IDLE;
            A_PAD:  state_r <= S_PAD;
            A_LEN:  state_r <= S_LEN;
            A_EMIT: begin
              state_r     <= S_EMIT;
              idx_r       <= '0;
              out_valid_r <= 1'b1;
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_EMIT: begin
          if (out_ready) begin
            if (idx_r == LAST_IDX) begin
              state_r     <= S_IDLE;
              out_valid_r <= 1'b0;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/sha_md_dp.sv
// Datapath of the SHA-256 core: block window, length counter, round logic
// and chaining words. Depends on sha_md_pkg.
module sha_md_dp import sha_md_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  sha_md_cmd_t       cmd,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic [IDX_W-1:0]  word_idx,
  output sha_md_sts_t       sts,
  output logic [WORD_W-1:0] digest_word
);

  localparam logic [WORD_W-1:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [WORD_W-1:0] H_INIT [DIG_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h80;

  function automatic logic [WORD_W-1:0] ror(input logic [WORD_W-1:0] x, input int n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  logic [WORD_W-1:0]  chain_r [DIG_WORDS];
  logic [WORD_W-1:0]  wv_r    [DIG_WORDS];   // working variables a..h
  logic [WORD_W-1:0]  win_r   [16];          // block buffer and schedule window
  logic [WORD_W-1:0]  win_nxt [16];
  logic [COUNT_W-1:0] count_r;
  logic [5:0]         pos;
  logic [63:0]        bit_len;
  logic [WORD_W-1:0]  s0, s1, w_new, t1, t2, big_s0, big_s1, ch, maj;

  assign pos     = count_r[5:0];
  assign bit_len = {count_r, 3'b000};
  assign sts.pos_last = (pos == 6'd63);
  assign sts.pos_hi   = (pos >= 6'd56);
  assign digest_word  = chain_r[word_idx];

  // Message schedule: the window slides by one word per round.
  assign s0    = ror(win_r[1], 7) ^ ror(win_r[1], 18) ^ (win_r[1] >> 3);
  assign s1    = ror(win_r[14], 17) ^ ror(win_r[14], 19) ^ (win_r[14] >> 10);
  assign w_new = win_r[0] + s0 + win_r[9] + s1;

  // Round function.
  assign big_s1 = ror(wv_r[4], 6) ^ ror(wv_r[4], 11) ^ ror(wv_r[4], 25);
  assign ch     = (wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]);
  assign t1     = wv_r[7] + big_s1 + ch + K_TAB[cmd.rnd_idx] + win_r[0];
  assign big_s0 = ror(wv_r[0], 2) ^ ror(wv_r[0], 13) ^ ror(wv_r[0], 22);
  assign maj    = (wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]);
  assign t2     = big_s0 + maj;

  always_comb begin
    logic [5:0]        bi;
    logic [BYTE_W-1:0] cur;
    bi      = '0;
    cur     = '0;
    win_nxt = win_r;
    if (cmd.absorb) begin
      win_nxt[pos[5:2]][{~pos[1:0], 3'b000} +: BYTE_W] = data_byte;
    end else if (cmd.pad) begin
      for (int w = 0; w < 16; w++) begin
        for (int b = 0; b < 4; b++) begin
          bi  = 6'(w * 4 + b);
          cur = win_r[w][(3 - b) * BYTE_W +: BYTE_W];
          if (bi == pos) begin
            cur = PAD_BYTE;
          end else if (bi > pos) begin
            cur = '0;
          end
          win_nxt[w][(3 - b) * BYTE_W +: BYTE_W] = cur;
        end
      end
      if (!sts.pos_hi) begin
        win_nxt[14] = bit_len[63:32];
        win_nxt[15] = bit_len[31:0];
      end
    end else if (cmd.len_blk) begin
      for (int w = 0; w < 14; w++) begin
        win_nxt[w] = '0;
      end
      win_nxt[14] = bit_len[63:32];
      win_nxt[15] = bit_len[31:0];
    end else if (cmd.round) begin
      for (int w = 0; w < 15; w++) begin
        win_nxt[w] = win_r[w + 1];
      end
      win_nxt[15] = w_new;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (cmd.load) begin
      wv_r <= chain_r;
    end else if (cmd.round) begin
      wv_r[0] <= t1 + t2;
      wv_r[1] <= wv_r[0];
      wv_r[2] <= wv_r[1];
      wv_r[3] <= wv_r[2];
      wv_r[4] <= wv_r[3] + t1;
      wv_r[5] <= wv_r[4];
      wv_r[6] <= wv_r[5];
      wv_r[7] <= wv_r[6];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      chain_r <= H_INIT;
      count_r <= '0;
    end else begin
      if (cmd.absorb) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.add) begin
        for (int i = 0; i < DIG_WORDS; i++) begin
          chain_r[i] <= chain_r[i] + wv_r[i];
        end
      end
    end
  end

endmodule

// File: rtl/sha256_message_digest_core.sv
// SHA-256 message digest core: byte words in, eight digest words out.
// A byte word that fills a block starts a compression (load, 64 rounds of the
// single round unit, fold). The end-of-message word starts padding and compression,
// with a second block when the length spills over, then eight digest words go out
// at one per cycle while out_ready is high. New byte words are taken only while idle.
// Reset (rst_n low, synchronous) restores the initial hash values and a zero length.
module sha256_message_digest_core import sha_md_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  sha_md_in_if.sink    in_ch,
  sha_md_out_if.source out_ch
);

  // The controller and datapath talk through these two structs and the digest word index.
  sha_md_cmd_t      cmd;
  sha_md_sts_t      sts;
  logic [IDX_W-1:0] word_idx;

  // The controller accepts a word only while idle. A word that completes a
  // 64-byte block starts a compression; a word with the end flag starts the
  // padding sequence, after which the digest is read out.
  sha_md_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_has_byte (in_ch.has_byte),
    .in_eom      (in_ch.end_of_message),
    .in_ready    (in_ch.ready),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .word_idx    (word_idx),
    .sts         (sts),
    .cmd         (cmd)
  );

  // The datapath holds the block window, the length counter, the round unit
  // and the chaining words, which are read out directly as digest words.
  sha_md_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_ch.data_byte),
    .word_idx    (word_idx),
    .sts         (sts),
    .digest_word (out_ch.digest_word)
  );

  // The digest words go out in order, most significant first.
  assign out_ch.word_index = word_idx;
  assign out_ch.last_word  = (word_idx == LAST_IDX);

endmodule

// File: rtl/sha_md_chk.sv
// Port-level checks for the SHA-256 core, attached to the top level by bind.
// Depends on sha_md_pkg and sha256_message_digest_core.
module sha_md_chk import sha_md_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WORD_W-1:0] out_digest_word,
  input logic [IDX_W-1:0]  out_word_index,
  input logic              out_last_word
);

  // A stalled digest word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word)
      && $stable(out_word_index))
    else $error("digest word changed while stalled");

  // Intake is closed while the digest is being read out.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input open during digest readout");

  // Digest words come in order without gaps.
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_word |=>
      out_valid && (out_word_index == $past(out_word_index) + 1'b1))
    else $error("digest word index skipped");

  // The last flag marks exactly the final word.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == LAST_IDX)))
    else $error("last flag on wrong word");

  // After the final word the block returns to intake.
  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_word |=> !out_valid && in_ready)
    else $error("no return to intake after digest");

endmodule

bind sha256_message_digest_core sha_md_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_digest_word (out_ch.digest_word),
  .out_word_index  (out_ch.word_index),
  .out_last_word   (out_ch.last_word)
);
